[src/assert_macros.svh]
// -----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the rack joint transform, clocked on i_clk and
// disabled while i_rst_n is low.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RJT_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rjt assertion failed");
`define RJT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rjt assertion failed");
`else
`define RJT_ASSERT_IMPL(lbl, ante, cons)
`define RJT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[src/rjt_pkg.sv]
// -----------------------------------------------------------------------------
// rjt_pkg
// Types and constants shared by the rack joint transform pipeline.
// -----------------------------------------------------------------------------
`default_nettype none
package rjt_pkg;

    typedef struct packed {
        logic signed [31:0] phi_along;
        logic signed [31:0] phi_across;
        logic signed [31:0] phi_axial;
    } t_in;

    typedef struct packed {
        logic signed [31:0] cos_theta;
        logic signed [31:0] sin_theta;
        logic signed [31:0] offset_x;
        logic signed [31:0] offset_y;
        logic signed [31:0] entry_z;
    } t_out;

    // fields that ride beside the angle computation
    typedef struct packed {
        logic signed [31:0] along;
        logic signed [31:0] oy;
        logic signed [31:0] axial;
    } t_side;

    localparam logic [1:0] CFG_RADIUS       = 2'd0;
    localparam logic [1:0] CFG_TAN_PRESSURE = 2'd1;
    localparam logic [1:0] CFG_TAN_HELIX    = 2'd2;

    localparam int DIV_BITS = 80;     // 64-bit magnitude with 16 fraction bits
    localparam int QM_W     = 35;
    localparam int ANG_W    = 35;
    localparam int XY_W     = 34;

    localparam logic [QM_W-1:0]         TWO_PI_Q32  = 35'd26986075409;
    localparam logic signed [ANG_W-1:0] PI_Q30      = 35'sd3373259426;
    localparam logic signed [ANG_W-1:0] TWO_PI_Q30  = 35'sd6746518852;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 35'sd1686629713;
    localparam logic signed [XY_W-1:0]  GAIN_INV    = 34'sd652032874;
    localparam logic signed [XY_W-1:0]  ONE_Q30     = 34'sd1073741824;

    localparam logic [30:0] ATAN_HEAD [10] = '{
        31'd843314857, 31'd497837829, 31'd263043837, 31'd133525159, 31'd67021687,
        31'd33543516, 31'd16775851, 31'd8388437, 31'd4194283, 31'd2097149
    };

    function automatic logic [30:0] atan_q30(input int unsigned i);
        logic [30:0] v;
        if (i < 10) begin
            v = ATAN_HEAD[i];
        end else if (i <= 30) begin
            v = 31'(1) << (30 - i);
        end else begin
            v = '0;
        end
        return v;
    endfunction

endpackage
`default_nettype wire

[src/rjt_numer.sv]
// -----------------------------------------------------------------------------
// rjt_numer
// Three stages: products, first saturating sum, second sum and magnitude.
// -----------------------------------------------------------------------------
`default_nettype none
module rjt_numer import rjt_pkg::*; (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_en,
    input  wire               i_valid,
    input  t_in               i_data,
    input  wire        [30:0] i_radius,
    input  wire signed [31:0] i_tan_p,
    input  wire signed [31:0] i_tan_h,
    output logic              o_valid,
    output logic       [63:0] o_mag,
    output logic              o_pos,
    output t_side             o_side
);
    logic [2:0] r_v;
    logic signed [63:0] r_base, r_p1, r_p2, r_num1, r_p2b;
    t_side r_side1, r_side2, r_side3;
    logic [63:0] r_mag;
    logic r_pos;

    logic signed [33:0] oy_sum;
    logic signed [64:0] sum1, sum2;
    logic signed [63:0] n_num1, num;

    always_comb begin
        oy_sum = $signed({3'b0, i_radius}) + 34'(i_data.phi_across);
        sum1 = 65'(r_base) + 65'(r_p1);
        if (sum1[64] != sum1[63]) begin
            n_num1 = sum1[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
        end else begin
            n_num1 = sum1[63:0];
        end
        sum2 = 65'(r_num1) - 65'(r_p2b);
        if (sum2[64] != sum2[63]) begin
            num = sum2[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
        end else begin
            num = sum2[63:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_valid};
        end
        if (i_en) begin
            r_base <= 64'(i_data.phi_along) <<< 16;
            r_p1   <= 64'(i_data.phi_across) * 64'(i_tan_p);
            r_p2   <= 64'(i_data.phi_axial) * 64'(i_tan_h);
            r_side1.along <= i_data.phi_along;
            r_side1.axial <= i_data.phi_axial;
            r_side1.oy    <= (oy_sum > 34'sd2147483647) ? 32'sh7fffffff : oy_sum[31:0];
            r_num1  <= n_num1;
            r_p2b   <= r_p2;
            r_side2 <= r_side1;
            r_mag   <= num[63] ? 64'(-num) : 64'(num);
            r_pos   <= (num > 0);
            r_side3 <= r_side2;
        end
    end

    assign o_valid = r_v[2];
    assign o_mag   = r_mag;
    assign o_pos   = r_pos;
    assign o_side  = r_side3;
endmodule
`default_nettype wire

[src/rjt_divider.sv]
// -----------------------------------------------------------------------------
// rjt_divider
// Restoring divider, one quotient bit per stage; the quotient is kept
// reduced modulo 2*pi (Q.32) as its bits arrive.
// -----------------------------------------------------------------------------
`default_nettype none
module rjt_divider import rjt_pkg::*; (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_en,
    input  wire              i_valid,
    input  wire       [63:0] i_mag,
    input  wire              i_pos,
    input  t_side            i_side,
    input  wire       [30:0] i_radius,
    output logic             o_valid,
    output logic [QM_W-1:0]  o_qm,
    output logic             o_pos,
    output t_side            o_side
);
    logic                r_v    [DIV_BITS];
    logic [DIV_BITS-1:0] r_d    [DIV_BITS];
    logic [31:0]         r_rem  [DIV_BITS];
    logic [QM_W-1:0]     r_qm   [DIV_BITS];
    logic                r_pos  [DIV_BITS];
    t_side               r_side [DIV_BITS];

    logic [31:0] divisor;
    assign divisor = (i_radius == '0) ? 32'd1 : {1'b0, i_radius};

    for (genvar k = 0; k < DIV_BITS; k++) begin : g_stage
        logic                p_v, p_pos, qb;
        logic [DIV_BITS-1:0] p_d;
        logic [31:0]         p_rem, rem2;
        logic [QM_W-1:0]     p_qm;
        logic [QM_W:0]       qm2;
        t_side               p_side;

        if (k == 0) begin : g_first
            assign p_v    = i_valid;
            assign p_d    = {i_mag, 16'b0};
            assign p_rem  = '0;
            assign p_qm   = '0;
            assign p_pos  = i_pos;
            assign p_side = i_side;
        end else begin : g_next
            assign p_v    = r_v[k-1];
            assign p_d    = r_d[k-1];
            assign p_rem  = r_rem[k-1];
            assign p_qm   = r_qm[k-1];
            assign p_pos  = r_pos[k-1];
            assign p_side = r_side[k-1];
        end

        always_comb begin
            rem2 = {p_rem[30:0], p_d[DIV_BITS-1]};
            qb   = (rem2 >= divisor);
            qm2  = {p_qm, qb};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= p_v;
            end
            if (i_en) begin
                r_d[k]    <= {p_d[DIV_BITS-2:0], 1'b0};
                r_rem[k]  <= qb ? rem2 - divisor : rem2;
                r_qm[k]   <= (qm2 >= {1'b0, TWO_PI_Q32}) ? QM_W'(qm2 - {1'b0, TWO_PI_Q32})
                                                         : qm2[QM_W-1:0];
                r_pos[k]  <= p_pos;
                r_side[k] <= p_side;
            end
        end
    end

    assign o_valid = r_v[DIV_BITS-1];
    assign o_qm    = r_qm[DIV_BITS-1];
    assign o_pos   = r_pos[DIV_BITS-1];
    assign o_side  = r_side[DIV_BITS-1];
endmodule
`default_nettype wire

[src/rjt_cordic.sv]
// -----------------------------------------------------------------------------
// rjt_cordic
// Angle wrap and quadrant fold, unrolled rotation CORDIC, clamp and output
// register.
// -----------------------------------------------------------------------------
`default_nettype none
module rjt_cordic import rjt_pkg::*; #(
    parameter int STAGES = 30
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_en,
    input  wire             i_valid,
    input  wire [QM_W-1:0]  i_qm,
    input  wire             i_pos,
    input  t_side           i_side,
    output logic            o_valid,
    output t_out            o_data
);
    logic                     r_v    [STAGES+1];
    logic signed [XY_W-1:0]   r_x    [STAGES+1];
    logic signed [XY_W-1:0]   r_y    [STAGES+1];
    logic signed [ANG_W-1:0]  r_z    [STAGES+1];
    logic                     r_flip [STAGES+1];
    t_side                    r_side [STAGES+1];
    logic                     r_vout;
    t_out                     r_out;

    logic [QM_W-1:0]         m;
    logic signed [ANG_W-1:0] z0, z1, n_z;
    logic                    n_flip;

    always_comb begin
        m  = (i_pos && i_qm != '0) ? TWO_PI_Q32 - i_qm : i_qm;
        z0 = $signed({2'b0, m[QM_W-1:2]});
        z1 = (z0 > PI_Q30) ? z0 - TWO_PI_Q30 : z0;
        n_flip = 1'b0;
        n_z = z1;
        if (z1 > HALF_PI_Q30) begin
            n_z = z1 - PI_Q30;
            n_flip = 1'b1;
        end else if (z1 < -HALF_PI_Q30) begin
            n_z = z1 + PI_Q30;
            n_flip = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
        if (i_en) begin
            r_x[0]    <= GAIN_INV;
            r_y[0]    <= '0;
            r_z[0]    <= n_z;
            r_flip[0] <= n_flip;
            r_side[0] <= i_side;
        end
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_iter
        logic signed [XY_W-1:0]  dx, dy;
        logic signed [ANG_W-1:0] at;
        assign dx = r_y[i] >>> i;
        assign dy = r_x[i] >>> i;
        assign at = $signed({4'b0, atan_q30(i)});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else if (i_en) begin
                r_v[i+1] <= r_v[i];
            end
            if (i_en) begin
                if (r_z[i] >= 0) begin
                    r_x[i+1] <= r_x[i] - dx;
                    r_y[i+1] <= r_y[i] + dy;
                    r_z[i+1] <= r_z[i] - at;
                end else begin
                    r_x[i+1] <= r_x[i] + dx;
                    r_y[i+1] <= r_y[i] - dy;
                    r_z[i+1] <= r_z[i] + at;
                end
                r_flip[i+1] <= r_flip[i];
                r_side[i+1] <= r_side[i];
            end
        end
    end

    logic signed [XY_W-1:0] xc, yc, xf, yf;
    always_comb begin
        xc = r_x[STAGES];
        yc = r_y[STAGES];
        if (xc > ONE_Q30) xc = ONE_Q30;
        if (xc < -ONE_Q30) xc = -ONE_Q30;
        if (yc > ONE_Q30) yc = ONE_Q30;
        if (yc < -ONE_Q30) yc = -ONE_Q30;
        xf = r_flip[STAGES] ? -xc : xc;
        yf = r_flip[STAGES] ? -yc : yc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vout <= 1'b0;
        end else if (i_en) begin
            r_vout <= r_v[STAGES];
        end
        if (i_en) begin
            r_out.cos_theta <= xf[31:0];
            r_out.sin_theta <= yf[31:0];
            r_out.offset_x  <= r_side[STAGES].along;
            r_out.offset_y  <= r_side[STAGES].oy;
            r_out.entry_z   <= r_side[STAGES].axial;
        end
    end

    assign o_valid = r_vout;
    assign o_data  = r_out;
endmodule
`default_nettype wire

[src/rack_joint_transform.sv]
// -----------------------------------------------------------------------------
// rack_joint_transform
// Rotation and translation terms of a rack joint from three joint variables.
// -----------------------------------------------------------------------------
// Fully pipelined: one transfer per cycle in and out while the output is not
// stalled. The restoring divider resolves one quotient bit per stage, and each
// CORDIC iteration has its own stage. The whole pipe holds while a finished
// result is stalled at the output. Config writes must land while the pipe is empty.
`default_nettype none
`include "assert_macros.svh"
module rack_joint_transform import rjt_pkg::*; #(
    parameter int CORDIC_STAGES = 30
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  t_in         i_data,
    output logic        o_valid,
    input  wire         i_stall,
    output t_out        o_data,
    input  wire         i_cfg_we,
    input  wire  [7:0]  i_cfg_idx,
    input  wire  [31:0] i_cfg_data
);
    logic [30:0]        r_radius;
    logic signed [31:0] r_tan_p, r_tan_h;
    logic               en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= 31'd65536;
            r_tan_p  <= 32'sd23853;
            r_tan_h  <= '0;
        end else if (i_cfg_we && i_cfg_idx[7:2] == '0) begin
            unique case (i_cfg_idx[1:0])
                CFG_RADIUS:       r_radius <= i_cfg_data[30:0];
                CFG_TAN_PRESSURE: r_tan_p  <= i_cfg_data;
                CFG_TAN_HELIX:    r_tan_h  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    logic        n_valid, d_valid, d_pos, n_pos;
    logic [63:0] n_mag;
    logic [QM_W-1:0] d_qm;
    t_side       n_side, d_side;

    rjt_numer u_numer (
        .i_clk, .i_rst_n, .i_en(en), .i_valid, .i_data,
        .i_radius(r_radius), .i_tan_p(r_tan_p), .i_tan_h(r_tan_h),
        .o_valid(n_valid), .o_mag(n_mag), .o_pos(n_pos), .o_side(n_side)
    );

    rjt_divider u_div (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(n_valid), .i_mag(n_mag),
        .i_pos(n_pos), .i_side(n_side), .i_radius(r_radius),
        .o_valid(d_valid), .o_qm(d_qm), .o_pos(d_pos), .o_side(d_side)
    );

    rjt_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(d_valid), .i_qm(d_qm),
        .i_pos(d_pos), .i_side(d_side), .o_valid, .o_data
    );

    logic cos_in_range, sin_in_range;
    assign cos_in_range = o_data.cos_theta <= 32'sd1073741824 &&
                          o_data.cos_theta >= -32'sd1073741824;
    assign sin_in_range = o_data.sin_theta <= 32'sd1073741824 &&
                          o_data.sin_theta >= -32'sd1073741824;

    `RJT_ASSERT_IMPL(a_qm_reduced, d_valid, d_qm < TWO_PI_Q32)
    `RJT_ASSERT_IMPL(a_cos_range, o_valid, cos_in_range)
    `RJT_ASSERT_IMPL(a_sin_range, o_valid, sin_in_range)
    `RJT_ASSERT_NEXT(a_hold_stall, o_valid && i_stall, o_valid)
endmodule
`default_nettype wire

[verif/rack_joint_transform_tb.sv]
// -----------------------------------------------------------------------------
// rack_joint_transform_tb
// Self-checking bench: directed and random joint variables across several
// register settings, with bursty input, receiver stalls and one long output
// hold-off. Each output transfer is checked against an in-bench prediction.
// -----------------------------------------------------------------------------
`default_nettype none
module rack_joint_transform_tb;
    import rjt_pkg::*;

    localparam int        PIPE_LAT    = 115;
    localparam int        IDLE_LIMIT  = 4000;
    localparam int        STAGES      = 30;
    localparam logic [7:0] IDX_RADIUS = 8'(CFG_RADIUS);
    localparam logic [7:0] IDX_TAN_P  = 8'(CFG_TAN_PRESSURE);
    localparam logic [7:0] IDX_TAN_H  = 8'(CFG_TAN_HELIX);
    localparam logic [7:0] IDX_UNUSED = 8'd3;
    localparam logic [7:0] IDX_TOP    = 8'hFF;

    localparam longint P_Q32    = 64'd26986075409;
    localparam longint PI30     = 64'd3373259426;
    localparam longint TWO_PI30 = 64'd6746518852;
    localparam longint HALF_PI30 = 64'd1686629713;
    localparam longint ONE30    = 64'd1073741824;
    localparam longint ARC_TBL [10] = '{
        843314857, 497837829, 263043837, 133525159, 67021687,
        33543516, 16775851, 8388437, 4194283, 2097149
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    t_in         i_data = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    t_out        o_data;
    logic        i_cfg_we = 1'b0;
    logic [7:0]  i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;

    rack_joint_transform u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // bench copy of the registers
    logic [30:0] pin_radius = 31'd65536;
    longint      pin_tan_p = 23853;
    longint      pin_tan_h = 0;

    t_out   matrix_q[$];
    int     errors = 0;
    int     n_sent = 0;
    int     n_seen = 0;
    int     burst_left = 0;
    bit     gaps_on = 1'b1;
    int     stall_mode = 0;
    int     hold_cnt = 0;
    int     idle_cnt = 0;
    longint cyc = 0;

    function automatic longint add_sat64(longint a, longint b);
        logic signed [64:0] s;
        s = $signed({a[63], a}) + $signed({b[63], b});
        if (s[64] != s[63]) return s[64] ? 64'h8000000000000000 : 64'h7FFFFFFFFFFFFFFF;
        return s[63:0];
    endfunction

    function automatic t_out joint_matrix(t_in d);
        t_out r;
        longint along, across, axial, num, z, x, y, dx, dy, oy, arc;
        longint unsigned mag, div, q1, q2, m;
        bit flip;
        along = d.phi_along;
        across = d.phi_across;
        axial = d.phi_axial;
        num = along * 65536;
        num = add_sat64(num, across * pin_tan_p);
        num = add_sat64(num, -(axial * pin_tan_h));
        mag = num;
        if (num < 0) mag = ~mag + 64'd1;
        div = (pin_radius == 0) ? 64'd1 : 64'(pin_radius);
        q1 = mag / div;
        q2 = ((mag % div) << 16) / div;
        m = ((q1 % P_Q32) * 64'd65536 + q2) % P_Q32;
        if (num > 0 && m != 0) m = P_Q32 - m;
        z = longint'(m >> 2);
        if (z > PI30) z -= TWO_PI30;
        flip = 1'b0;
        if (z > HALF_PI30) begin
            z -= PI30;
            flip = 1'b1;
        end else if (z < -HALF_PI30) begin
            z += PI30;
            flip = 1'b1;
        end
        x = 652032874;
        y = 0;
        for (int i = 0; i < STAGES; i++) begin
            arc = (i < 10) ? ARC_TBL[i] : (i <= 30 ? (longint'(1) << (30 - i)) : 0);
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= arc;
            end else begin
                x += dx; y -= dy; z += arc;
            end
        end
        if (x > ONE30) x = ONE30;
        if (x < -ONE30) x = -ONE30;
        if (y > ONE30) y = ONE30;
        if (y < -ONE30) y = -ONE30;
        if (flip) begin
            x = -x; y = -y;
        end
        oy = longint'(pin_radius) + across;
        if (oy > 64'sd2147483647) oy = 64'sd2147483647;
        r.cos_theta = x[31:0];
        r.sin_theta = y[31:0];
        r.offset_x  = d.phi_along;
        r.offset_y  = oy[31:0];
        r.entry_z   = d.phi_axial;
        return r;
    endfunction

    task automatic field_cmp(string name, logic [31:0] e, logic [31:0] a);
        if (e !== a) begin
            errors++;
            $display("%0t: %s mismatch, expected %h got %h", $time, name, e, a);
        end
    endtask

    // output checker and watchdog
    always @(posedge i_clk) begin
        t_out e;
        cyc <= cyc + 1;
        if (i_rst_n && o_valid && !i_stall) begin
            n_seen++;
            if (matrix_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected transfer, expected none got %h", $time, o_data);
            end else begin
                e = matrix_q.pop_front();
                field_cmp("cos_theta", e.cos_theta, o_data.cos_theta);
                field_cmp("sin_theta", e.sin_theta, o_data.sin_theta);
                field_cmp("offset_x", e.offset_x, o_data.offset_x);
                field_cmp("offset_y", e.offset_y, o_data.offset_y);
                field_cmp("entry_z", e.entry_z, o_data.entry_z);
            end
        end
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cnt <= 0;
        else idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= IDLE_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding", $time, matrix_q.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver stall pattern, with an optional long hold-off
    always @(negedge i_clk) begin
        if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            i_stall <= 1'b1;
        end else begin
            case (stall_mode)
                1: i_stall <= ($urandom_range(0, 99) < 30);
                2: i_stall <= (cyc % 7) < 3;
                3: i_stall <= ($urandom_range(0, 99) < 80);
                default: i_stall <= 1'b0;
            endcase
        end
    end

    task automatic send_item(t_in d);
        @(negedge i_clk);
        if (gaps_on && burst_left == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(0, 8)) @(negedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        i_valid = 1'b1;
        i_data = d;
        if (burst_left > 0) burst_left--;
        do @(posedge i_clk); while (o_stall);
        matrix_q.push_back(joint_matrix(d));
        n_sent++;
    endtask

    task automatic send_vars(logic [31:0] a, logic [31:0] b, logic [31:0] c);
        t_in d;
        d.phi_along = a;
        d.phi_across = b;
        d.phi_axial = c;
        send_item(d);
    endtask

    function automatic logic [31:0] rnd_field();
        case ($urandom_range(0, 3))
            0: return 32'($signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000);
            1: return 32'($signed($urandom_range(0, 32'h3FFFFFF)) - 32'sh2000000);
            default: return $urandom;
        endcase
    endfunction

    // pipe empty: let in-flight work finish before touching registers
    task automatic drain();
        @(negedge i_clk);
        i_valid = 1'b0;
        wait (matrix_q.size() == 0);
        repeat (PIPE_LAT + 10) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [7:0] idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            IDX_RADIUS: pin_radius = val[30:0];
            IDX_TAN_P:  pin_tan_p = longint'($signed(val));
            IDX_TAN_H:  pin_tan_h = longint'($signed(val));
            default: ;
        endcase
    endtask

    task automatic set_regs(logic [31:0] rad, logic [31:0] tp, logic [31:0] th);
        drain();
        write_reg(IDX_RADIUS, rad);
        write_reg(IDX_TAN_P, tp);
        write_reg(IDX_TAN_H, th);
    endtask

    task automatic test_field_extremes();
        logic [31:0] ext [5] = '{32'h0, 32'h1, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000};
        stall_mode = 0;
        for (int i = 0; i < 5; i++) send_vars(ext[i], ext[(i + 1) % 5], ext[(i + 3) % 5]);
        send_vars(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        send_vars(32'h80000000, 32'h80000000, 32'h80000000);
        send_vars(32'h00010000, 32'h0, 32'h0);
        send_vars(32'hFFFF0000, 32'h0, 32'h0);
    endtask

    task automatic test_zero_radius();
        set_regs(32'h0, 32'd23853, 32'h0);
        send_vars(32'h0, 32'h0, 32'h0);
        send_vars(32'h00000001, 32'h0, 32'h0);
        send_vars(32'hFFFFFFFF, 32'h80000000, 32'h12345678);
        send_vars(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h0);
    endtask

    task automatic test_sum_saturation();
        // the first setting gives products near 2^62 of opposite sign; subtracting one pushes the sum past int64
        set_regs(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000);
        send_vars(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        send_vars(32'h80000000, 32'h80000000, 32'h80000000);
        set_regs(32'h00000001, 32'h80000000, 32'h7FFFFFFF);
        send_vars(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
        send_vars(32'h80000000, 32'h7FFFFFFF, 32'h80000000);
    endtask

    task automatic test_unknown_index();
        drain();
        write_reg(IDX_UNUSED, $urandom);
        write_reg(IDX_TOP, $urandom);
        // bit 31 of the radius write is dropped
        write_reg(IDX_RADIUS, 32'hFFFFFFFF);
        send_vars(32'h00001000, 32'h7FFFFFFF, 32'h00000100);
        send_vars(32'h00001000, 32'h00000001, 32'h00000100);
    endtask

    task automatic test_random_settings();
        logic [31:0] rad_set [5] = '{32'd65536, 32'd1, 32'h7FFFFFFF, 32'd0, 32'd0};
        logic [31:0] tp_set  [5] = '{32'd23853, 32'h7FFFFFFF, 32'h80000000, 32'd0, 32'd0};
        logic [31:0] th_set  [5] = '{32'd0, 32'h80000000, 32'h7FFFFFFF, 32'd0, 32'd0};
        for (int p = 0; p < 5; p++) begin
            if (p >= 3) begin
                rad_set[p] = $urandom_range(1, 32'h00400000);
                tp_set[p] = rnd_field();
                th_set[p] = rnd_field();
            end
            set_regs(rad_set[p], tp_set[p], th_set[p]);
            stall_mode = p % 4;
            gaps_on = (p != 1);
            for (int k = 0; k < 130; k++) send_vars(rnd_field(), rnd_field(), rnd_field());
        end
        gaps_on = 1'b1;
    endtask

    task automatic test_backpressure();
        set_regs(32'd65536, 32'd23853, 32'd12000);
        stall_mode = 1;
        gaps_on = 1'b0;
        hold_cnt = 400;
        for (int k = 0; k < 180; k++) send_vars(rnd_field(), rnd_field(), rnd_field());
        gaps_on = 1'b1;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_field_extremes();
        test_zero_radius();
        test_sum_saturation();
        test_unknown_index();
        test_random_settings();
        test_backpressure();
        drain();
        $display("Covered %0d transfers in, %0d out: field extremes, zero radius,", n_sent, n_seen);
        $display("sum saturation, ignored register indexes, random settings and long hold-off.");
        if (errors == 0 && matrix_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
